FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");

// Clocked overlapping implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	`ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons))

// Clocked next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	`ASSERT_CLK(lbl, clk, rstn, (ante) |=> (cons))

`endif

FILE: hdl/isq_pkg.sv
// Types and constants for the indexed sequence store.
package isq_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 16;
	localparam int VAL_W    = 32;
	localparam int LEN_W    = 9;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		REQ_READ   = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_APPEND = 2'd2,
		REQ_DELETE = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDATA,
		S_UP_RD,
		S_UP_WR,
		S_PLACE,
		S_DN_RD,
		S_DN_WR,
		S_DONE
	} seq_state_t;

endpackage

FILE: hdl/isq_if.sv
// Request and response channel interfaces.
interface isq_req_if import isq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	req_type_t               req_type;
	logic signed [POS_W-1:0] position;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, req_type, position, item_value, input ready);
	modport sink   (input valid, req_type, position, item_value, output ready);
	modport mon    (input valid, ready, req_type, position, item_value);
endinterface

interface isq_rsp_if import isq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] read_value;
	logic                    found;
	status_t                 status;
	logic [LEN_W-1:0]        length_now;

	modport source (output valid, read_value, found, status, length_now, input ready);
	modport sink   (input valid, read_value, found, status, length_now, output ready);
	modport mon    (input valid, ready, read_value, found, status, length_now);
endinterface

FILE: hdl/indexed_sequence_store.sv
// Indexed sequence store: ordered list of values in a single-port-read memory.
// A read passes through a memory-data state, an append writes in place, and a rejected
// request goes straight to the done state; insert at p shifts entries p..L-1 up first.
// Requests: one at a time, the next one taken in the cycle after the result loads;
// the shift loop moves one entry at a time (read, write one over).
// Reset clears the length and control state; memory contents stay unwritten.
module indexed_sequence_store import isq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	isq_req_if.sink    req,
	isq_rsp_if.source  rsp
);

	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] mem_rdata_q;
	logic             mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [ADDR_W-1:0] mem_ra;
	logic [VAL_W-1:0] mem_wd;

	seq_state_t       state_q, state_d;
	logic [CNT_W-1:0] len_q, len_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] at_q, at_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [VAL_W-1:0] res_value_q, res_value_d;
	logic             res_found_q, res_found_d;
	status_t          res_status_q, res_status_d;

	logic             rsp_valid_q, rsp_valid_d;
	logic [VAL_W-1:0] rsp_value_q;
	logic             rsp_found_q;
	status_t          rsp_status_q;
	logic [LEN_W-1:0] rsp_len_q;
	logic             out_load;

	logic             pos_neg;
	logic [CMP_W-1:0] pos_u;
	logic [CMP_W-1:0] len_x;
	logic             pos_inside;
	logic             pos_beyond;
	logic             is_full;
	logic [CNT_W-1:0] at_ins;
	logic [CNT_W-1:0] idx_dec;
	logic [CNT_W:0]   idx_inc2;

	assign pos_neg    = req.position[POS_W-1];
	assign pos_u      = CMP_W'(req.position[POS_W-2:0]);
	assign len_x      = CMP_W'(len_q);
	assign pos_inside = !pos_neg && (pos_u < len_x);
	assign pos_beyond = !pos_neg && (pos_u > len_x);
	assign is_full    = len_q >= CNT_W'(CAPACITY);
	assign at_ins     = (pos_neg || pos_u == '0) ? '0 : CNT_W'(pos_u);
	assign idx_dec    = idx_q - CNT_W'(1);
	assign idx_inc2   = {1'b0, idx_q} + (CNT_W+1)'(2);

	always_comb begin
		state_d      = state_q;
		len_d        = len_q;
		idx_d        = idx_q;
		at_d         = at_q;
		val_d        = val_q;
		res_value_d  = res_value_q;
		res_found_d  = res_found_q;
		res_status_d = res_status_q;
		mem_we       = 1'b0;
		mem_wa       = ADDR_W'(at_q);
		mem_wd       = val_q;
		mem_ra       = ADDR_W'(pos_u);
		req.ready    = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready    = 1'b1;
				res_value_d  = '0;
				res_found_d  = 1'b0;
				res_status_d = ST_DONE;
				if (req.valid) begin
					case (req.req_type)
						REQ_READ: begin
							if (pos_inside) begin
								state_d = S_RDATA;
							end else begin
								res_value_d  = '1;
								res_status_d = ST_RANGE;
								state_d      = S_DONE;
							end
						end
						REQ_INSERT: begin
							val_d = req.item_value;
							at_d  = at_ins;
							idx_d = len_q;
							if (pos_beyond) begin
								res_status_d = ST_RANGE;
								state_d      = S_DONE;
							end else if (is_full) begin
								res_status_d = ST_FULL;
								state_d      = S_DONE;
							end else if (len_q == at_ins) begin
								state_d = S_PLACE;
							end else begin
								state_d = S_UP_RD;
							end
						end
						REQ_APPEND: begin
							val_d = req.item_value;
							at_d  = len_q;
							if (is_full) begin
								res_status_d = ST_FULL;
								state_d      = S_DONE;
							end else begin
								state_d = S_PLACE;
							end
						end
						REQ_DELETE: begin
							idx_d = CNT_W'(pos_u);
							if (!pos_inside) begin
								res_status_d = ST_RANGE;
								state_d      = S_DONE;
							end else if (CMP_W'(pos_u + CMP_W'(1)) < len_x) begin
								state_d = S_DN_RD;
							end else begin
								len_d       = len_q - CNT_W'(1);
								res_found_d = 1'b1;
								state_d     = S_DONE;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RDATA: begin
				res_value_d = mem_rdata_q;
				res_found_d = 1'b1;
				state_d     = S_DONE;
			end
			S_UP_RD: begin
				mem_ra  = ADDR_W'(idx_dec);
				state_d = S_UP_WR;
			end
			S_UP_WR: begin
				mem_we = 1'b1;
				mem_wa = ADDR_W'(idx_q);
				mem_wd = mem_rdata_q;
				idx_d  = idx_dec;
				state_d = (idx_dec == at_q) ? S_PLACE : S_UP_RD;
			end
			S_PLACE: begin
				mem_we      = 1'b1;
				mem_wa      = ADDR_W'(at_q);
				mem_wd      = val_q;
				len_d       = len_q + CNT_W'(1);
				res_found_d = 1'b1;
				state_d     = S_DONE;
			end
			S_DN_RD: begin
				mem_ra  = ADDR_W'(idx_q + CNT_W'(1));
				state_d = S_DN_WR;
			end
			S_DN_WR: begin
				mem_we = 1'b1;
				mem_wa = ADDR_W'(idx_q);
				mem_wd = mem_rdata_q;
				idx_d  = idx_q + CNT_W'(1);
				if (idx_inc2 < {1'b0, len_q}) begin
					state_d = S_DN_RD;
				end else begin
					len_d       = len_q - CNT_W'(1);
					res_found_d = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		if (out_load) begin
			rsp_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		at_q         <= at_d;
		val_q        <= val_d;
		res_value_q  <= res_value_d;
		res_found_q  <= res_found_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			rsp_value_q  <= res_value_q;
			rsp_found_q  <= res_found_q;
			rsp_status_q <= res_status_q;
			rsp_len_q    <= LEN_W'(len_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rdata_q <= mem[mem_ra];
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.found      = rsp_found_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.length_now = rsp_len_q;

endmodule

FILE: hdl/isq_checker.sv
// Port-level assertions for the indexed sequence store, with its bind.
`include "assert_macros.svh"

module isq_checker import isq_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [VAL_W-1:0] rsp_read_value,
	input logic             rsp_found,
	input status_t          rsp_status,
	input logic [LEN_W-1:0] rsp_length_now
);

	logic [VAL_W+LEN_W+2:0] rsp_payload;

	assign rsp_payload = {rsp_read_value, rsp_found, rsp_status, rsp_length_now};

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
	`ASSERT_IMPL(a_found_done, clk, arst_n, rsp_valid, rsp_found == (rsp_status == ST_DONE))
	`ASSERT_IMPL(a_len_cap, clk, arst_n, rsp_valid, 32'(rsp_length_now) <= 32'(CAPACITY))
	`ASSERT_NEXT(a_one_at_time, clk, arst_n, req_valid && req_ready, !req_ready)

endmodule

bind indexed_sequence_store isq_checker u_isq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_found      (rsp.found),
	.rsp_status     (rsp.status),
	.rsp_length_now (rsp.length_now)
);
